/* src/gtl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared types, character codes and the transliteration table for the
// Greek to Latin transliterator.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // held letter codes
  typedef enum logic [2:0] {
    PEND_NONE    = 3'd0,
    PEND_NU_CAP  = 3'd1,
    PEND_NU_SML  = 3'd2,
    PEND_MU_CAP  = 3'd3,
    PEND_MU_SML  = 3'd4
  } pend_t;

  localparam logic [7:0] CODE_MU_CAP  = 8'd204;
  localparam logic [7:0] CODE_NU_CAP  = 8'd205;
  localparam logic [7:0] CODE_PI_CAP  = 8'd208;
  localparam logic [7:0] CODE_TAU_CAP = 8'd212;
  localparam logic [7:0] CODE_MU_SML  = 8'd236;
  localparam logic [7:0] CODE_NU_SML  = 8'd237;
  localparam logic [7:0] CODE_PI_SML  = 8'd240;
  localparam logic [7:0] CODE_TAU_SML = 8'd244;

  localparam logic [7:0] CH_APOS = 8'd39;
  localparam logic [7:0] CH_QUOT = 8'd34;
  localparam logic [7:0] CH_NUL  = 8'd0;

  // up to four characters from one input item
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      count;
  } burst_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } xlat_t;

  function automatic xlat_t mk1(input logic [7:0] a);
    mk1 = '{len: 2'd1, c0: a, c1: CH_NUL, c2: CH_NUL};
  endfunction

  function automatic xlat_t mk2(input logic [7:0] a, input logic [7:0] b);
    mk2 = '{len: 2'd2, c0: a, c1: b, c2: CH_NUL};
  endfunction

  function automatic xlat_t mk3(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c);
    mk3 = '{len: 2'd3, c0: a, c1: b, c2: c};
  endfunction

  // table lookup; bytes outside the table pass through
  function automatic xlat_t xlat_lookup(input logic [7:0] c);
    xlat_t r;
    unique case (c)
      8'd193: r = mk1("A");
      8'd194: r = mk1("V");
      8'd195: r = mk1("G");
      8'd196: r = mk1("D");
      8'd197: r = mk1("E");
      8'd198: r = mk1("Z");
      8'd199: r = mk1("H");
      8'd200: r = mk1("8");
      8'd201: r = mk1("I");
      8'd202: r = mk1("K");
      8'd203: r = mk1("L");
      8'd204: r = mk1("M");
      8'd205: r = mk1("N");
      8'd206: r = mk2("K", "S");
      8'd207: r = mk1("O");
      8'd208: r = mk1("P");
      8'd209: r = mk1("R");
      8'd211: r = mk1("S");
      8'd212: r = mk1("T");
      8'd213: r = mk1("Y");
      8'd214: r = mk1("F");
      8'd215: r = mk1("X");
      8'd216: r = mk2("P", "S");
      8'd217: r = mk1("W");
      8'd225: r = mk1("a");
      8'd226: r = mk1("v");
      8'd227: r = mk1("g");
      8'd228: r = mk1("d");
      8'd229: r = mk1("e");
      8'd230: r = mk1("z");
      8'd231: r = mk1("h");
      8'd232: r = mk1("8");
      8'd233: r = mk1("i");
      8'd234: r = mk1("k");
      8'd235: r = mk1("l");
      8'd236: r = mk1("m");
      8'd237: r = mk1("n");
      8'd238: r = mk2("k", "s");
      8'd239: r = mk1("o");
      8'd240: r = mk1("p");
      8'd241: r = mk1("r");
      8'd242: r = mk1("s");
      8'd243: r = mk1("s");
      8'd244: r = mk1("t");
      8'd245: r = mk1("y");
      8'd246: r = mk1("f");
      8'd247: r = mk1("x");
      8'd248: r = mk2("p", "s");
      8'd249: r = mk1("w");
      8'd182: r = mk2(CH_APOS, "A");
      8'd184: r = mk2(CH_APOS, "E");
      8'd185: r = mk2(CH_APOS, "H");
      8'd186: r = mk2(CH_APOS, "I");
      8'd188: r = mk2(CH_APOS, "O");
      8'd190: r = mk2(CH_APOS, "Y");
      8'd191: r = mk2(CH_APOS, "W");
      8'd192: r = mk3("i", CH_APOS, CH_QUOT);
      8'd218: r = mk2("I", CH_QUOT);
      8'd219: r = mk2("Y", CH_QUOT);
      8'd220: r = mk2("a", CH_APOS);
      8'd221: r = mk2("e", CH_APOS);
      8'd222: r = mk2("h", CH_APOS);
      8'd223: r = mk2("i", CH_APOS);
      8'd224: r = mk3("u", CH_APOS, CH_QUOT);
      8'd250: r = mk2("i", CH_QUOT);
      8'd251: r = mk2("u", CH_QUOT);
      8'd252: r = mk2("o", CH_APOS);
      8'd253: r = mk2("u", CH_APOS);
      8'd254: r = mk2("w", CH_APOS);
      default: r = mk1(c);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] held_char(input pend_t p);
    logic [7:0] r;
    unique case (p)
      PEND_NU_CAP: r = "N";
      PEND_NU_SML: r = "n";
      PEND_MU_CAP: r = "M";
      PEND_MU_SML: r = "m";
      default:     r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/gtl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_in_if
// Input channel: character byte or end-of-stream mark.
// ----------------------------------------------------------------------------
interface gtl_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_char;

  modport source (output valid, output func, output in_char, input ready);
  modport sink   (input valid, input func, input in_char, output ready);
endinterface
`default_nettype wire

/* src/gtl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_out_if
// Output channel: one Latin character with an end-of-item mark.
// ----------------------------------------------------------------------------
interface gtl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

/* src/gtl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_front
// Accepts input transactions, tracks the held nu/mu and builds the burst of
// output characters for each item.
// ----------------------------------------------------------------------------
module gtl_front (
  input  wire logic            clk,
  input  wire logic            rst,
  gtl_in_if.sink               in_ch,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output gtl_pkg::burst_t      push_burst
);
  import gtl_pkg::*;

  pend_t pend;
  pend_t pend_next;
  xlat_t tx;
  logic  accept;
  logic  is_tau;
  logic  is_pi;
  logic  is_nu;
  logic  is_mu;
  logic  has_held;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  assign is_tau   = (in_ch.in_char == CODE_TAU_CAP) || (in_ch.in_char == CODE_TAU_SML);
  assign is_pi    = (in_ch.in_char == CODE_PI_CAP) || (in_ch.in_char == CODE_PI_SML);
  assign is_nu    = (in_ch.in_char == CODE_NU_CAP) || (in_ch.in_char == CODE_NU_SML);
  assign is_mu    = (in_ch.in_char == CODE_MU_CAP) || (in_ch.in_char == CODE_MU_SML);
  assign has_held = (pend != PEND_NONE);
  assign tx       = xlat_lookup(in_ch.in_char);

  always_comb begin
    push_burst.chars = '0;
    push_burst.count = 3'd0;
    pend_next        = PEND_NONE;
    if (in_ch.func) begin
      if (has_held) begin
        push_burst.chars[0] = held_char(pend);
        push_burst.count    = 3'd1;
      end
    end else if ((pend == PEND_NU_CAP || pend == PEND_NU_SML) && is_tau) begin
      push_burst.chars[0] = (pend == PEND_NU_CAP) ? "D" : "d";
      push_burst.count    = 3'd1;
    end else if ((pend == PEND_MU_CAP || pend == PEND_MU_SML) && is_pi) begin
      push_burst.chars[0] = (pend == PEND_MU_CAP) ? "B" : "b";
      push_burst.count    = 3'd1;
    end else begin
      if (has_held) begin
        push_burst.chars[0] = held_char(pend);
      end
      if (is_nu || is_mu) begin
        push_burst.count = {2'b00, has_held};
        unique case (in_ch.in_char)
          CODE_NU_CAP: pend_next = PEND_NU_CAP;
          CODE_NU_SML: pend_next = PEND_NU_SML;
          CODE_MU_CAP: pend_next = PEND_MU_CAP;
          default:     pend_next = PEND_MU_SML;
        endcase
      end else begin
        // table text goes after the released letter, if any
        if (has_held) begin
          push_burst.chars[1] = tx.c0;
          push_burst.chars[2] = tx.c1;
          push_burst.chars[3] = tx.c2;
        end else begin
          push_burst.chars[0] = tx.c0;
          push_burst.chars[1] = tx.c1;
          push_burst.chars[2] = tx.c2;
        end
        push_burst.count = {1'b0, tx.len} + {2'b00, has_held};
      end
    end
  end

  assign push_valid = in_ch.valid && (push_burst.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

endmodule
`default_nettype wire

/* src/gtl_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_queue
// Short queue of character bursts between the front and the back.
// ----------------------------------------------------------------------------
module gtl_queue #(
  parameter int unsigned DEPTH = gtl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire gtl_pkg::burst_t push_burst,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output gtl_pkg::burst_t      pop_burst
);
  import gtl_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  burst_t          entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_burst  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_burst;
    end
  end

endmodule
`default_nettype wire

/* src/gtl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtl_back
// Serializes each burst onto the output channel, one character per
// transaction, marking the final one.
// ----------------------------------------------------------------------------
module gtl_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire gtl_pkg::burst_t pop_burst,
  gtl_out_if.source            out_ch
);
  import gtl_pkg::*;

  burst_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic       at_last;
  logic       take;

  assign at_last         = ({1'b0, idx} == (cur.count - 3'd1));
  assign out_ch.valid    = busy;
  assign out_ch.out_char = cur.chars[idx];
  assign out_ch.last     = at_last;

  // next burst loads as the final character of this one leaves
  assign pop_ready = !busy || (out_ch.ready && at_last);
  assign take      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && out_ch.ready) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= pop_burst;
    end
  end

endmodule
`default_nettype wire

/* src/greek_to_latin_transliterator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greek_to_latin_transliterator
// ISO 8859-7 byte stream in, Latin transliteration characters out.
//
//   channel      dir  payload              notes
//   in_stream    in   func, in_char        func=1 ends the stream
//   out_stream   out  out_char, last       last on final char of an item
//
// An input transaction is taken every cycle while the burst queue has room;
// each item yields zero to four output characters, sent one per cycle while
// the output is ready. Output rate is set by the serializer; new items are
// taken while earlier ones are sent. Each burst goes through the queue and
// the serializer's burst register. Reset clears the held letter, the queue
// and the serializer. Output stalls back up through the queue to the input.
// ----------------------------------------------------------------------------
module greek_to_latin_transliterator #(
  parameter int unsigned QUEUE_DEPTH = gtl_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  gtl_in_if.sink    in_stream,
  gtl_out_if.source out_stream
);
  import gtl_pkg::*;

  logic   push_valid;
  logic   push_ready;
  burst_t push_burst;
  logic   pop_valid;
  logic   pop_ready;
  burst_t pop_burst;

  gtl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_stream),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_burst (push_burst)
  );

  gtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_burst (push_burst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_burst  (pop_burst)
  );

  gtl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_burst (pop_burst),
    .out_ch    (out_stream)
  );

endmodule
`default_nettype wire
